>>> src/xal_pkg.sv
`default_nettype none

package xal_pkg;

   // Pixel width; inputs and full scale are masked to this many bits
   localparam int PIXEL_BITS = 16;
   // Port width of the pixel and full-scale fields
   localparam int PORT_W = 16;
   // Fraction bits of log2
   localparam int FRAC_BITS = 24;
   // Width of the top-bit index
   localparam int K_W = $clog2(PIXEL_BITS);
   // log2 value width, integer and fraction
   localparam int LOG_W = K_W + FRAC_BITS;
   // Normalized mantissa, Q1.31
   localparam int M_W = 32;
   // ln2 in Q0.32
   localparam int LN2_W = 32;
   localparam logic [LN2_W-1:0] LN2_Q32 = 32'hB17217F8;
   // Product of log difference and ln2
   localparam int PROD_W = LOG_W + LN2_W;
   // Rounding sum and output scaling
   localparam int SUM_W = 64;
   localparam int ATT_SHIFT = 40;
   localparam int ATT_W = 20;
   localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << (ATT_SHIFT - 1);
   // Iteration counter of the full-scale log unit
   localparam int ITER_W = $clog2(FRAC_BITS);
   // Full scale after reset
   localparam logic [PORT_W-1:0] FS_RESET = 16'hFFFF;

   // Item moving through the squaring stages
   typedef struct packed {
      logic [M_W-1:0]       m;
      logic [FRAC_BITS-1:0] frac;
      logic [K_W-1:0]       k;
      logic                 clamped;
   } xal_lane_type;

   typedef struct packed {
      logic [K_W-1:0] k;
      logic [M_W-1:0] m;
   } xal_norm_type;

   typedef struct packed {
      logic [M_W-1:0] m;
      logic           frac_bit;
   } xal_sq_type;

   // Mask to pixel width and force zero to one
   function automatic logic [PIXEL_BITS-1:0] fix_pix(input logic [PORT_W-1:0] x);
      logic [PIXEL_BITS-1:0] v;
      v = x[PIXEL_BITS-1:0];
      if (v == '0) begin
         v = PIXEL_BITS'(1);
      end
      return v;
   endfunction

   // Top set bit and mantissa in Q1.31; x is never zero
   function automatic xal_norm_type normalize(input logic [PIXEL_BITS-1:0] x);
      xal_norm_type r;
      r.k = '0;
      for (int i = 0; i < PIXEL_BITS; i++) begin
         if (x[i]) begin
            r.k = K_W'(i);
         end
      end
      r.m = M_W'(x) << (M_W - 1 - int'(r.k));
      return r;
   endfunction

   // One fraction bit of log2: square, truncate, renormalize
   function automatic xal_sq_type sq_step(input logic [M_W-1:0] m);
      logic [2*M_W-1:0] prod;
      logic [M_W:0]     hi;
      xal_sq_type       r;
      prod = {{M_W{1'b0}}, m} * {{M_W{1'b0}}, m};
      hi = prod[2*M_W-1:M_W-1];
      r.frac_bit = hi[M_W];
      r.m = hi[M_W] ? hi[M_W:1] : hi[M_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/xray_attenuation_log_core.sv
// X-ray attenuation core: attenuation = -ln(intensity / full_scale), Q4.16.
//
// Input channel req_*: one 16-bit pixel per item, req_valid / req_stall.
// Result channel rsp_*: attenuation and clamped flag, rsp_valid / rsp_stall.
// CSR: csr_wr_en with csr_wr_data writes full_scale; write only while idle.
//
// The pipeline from accept to rsp_valid has one prep stage, 24 squaring
// stages (one 32x32 multiplier each, one log2 fraction bit per stage) and
// three stages for subtract, ln2 multiply and rounding.
// Throughput is one item per cycle while req_stall and rsp_stall are low.
//
// After reset, and after each CSR write, the full-scale log is computed by
// an iterative unit sharing one multiplier; req_stall is high during that
// time. Reset clears every valid bit and sets full_scale to 65535.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// holds req_stall only once the stage at the input is occupied and blocked.

`default_nettype none

module xray_attenuation_log_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [xal_pkg::PORT_W-1:0] req_intensity,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [xal_pkg::ATT_W-1:0]       rsp_attenuation,
   output logic                            rsp_clamped,
   input  wire logic                       csr_wr_en,
   input  wire logic [xal_pkg::PORT_W-1:0] csr_wr_data
);
   import xal_pkg::*;

   logic [PIXEL_BITS-1:0] fs;
   logic [LOG_W-1:0]      lfs;
   logic                  fs_busy;
   logic                  prep_ready;
   logic                  lane_valid [0:FRAC_BITS];
   logic                  lane_ready [0:FRAC_BITS];
   xal_lane_type          lane_data  [0:FRAC_BITS];

   // Full-scale register and its log
   xal_fs_log u_fs_log (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fs          (fs),
      .lfs         (lfs),
      .busy        (fs_busy)
   );

   assign req_stall = fs_busy || !prep_ready;

   // Input stage
   xal_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid && !fs_busy),
      .in_intensity (req_intensity),
      .fs           (fs),
      .in_ready     (prep_ready),
      .out_valid    (lane_valid[0]),
      .out_data     (lane_data[0]),
      .out_ready    (lane_ready[0])
   );

   // One squaring stage per fraction bit
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
      xal_sq_stage u_sq (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lane_valid[i]),
         .in_data   (lane_data[i]),
         .in_ready  (lane_ready[i]),
         .out_valid (lane_valid[i+1]),
         .out_data  (lane_data[i+1]),
         .out_ready (lane_ready[i+1])
      );
   end

   // Difference, ln2 scaling and output register
   xal_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (lane_valid[FRAC_BITS]),
      .in_data         (lane_data[FRAC_BITS]),
      .lfs             (lfs),
      .in_ready        (lane_ready[FRAC_BITS]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_attenuation (rsp_attenuation),
      .rsp_clamped     (rsp_clamped)
   );

endmodule

`default_nettype wire

>>> src/xal_prep.sv
`default_nettype none

module xal_prep (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [xal_pkg::PORT_W-1:0]     in_intensity,
   input  wire logic [xal_pkg::PIXEL_BITS-1:0] fs,
   output logic                                in_ready,
   output logic                                out_valid,
   output xal_pkg::xal_lane_type               out_data,
   input  wire logic                           out_ready
);
   import xal_pkg::*;

   logic                  valid_ff;
   xal_lane_type          data_ff;
   xal_lane_type          data_in;
   logic [PIXEL_BITS-1:0] pix;
   xal_norm_type          norm;

   // Mask, zero fix, range check and normalization
   always_comb begin
      pix = fix_pix(in_intensity);
      norm = normalize(pix);
      data_in.m = norm.m;
      data_in.k = norm.k;
      data_in.frac = '0;
      data_in.clamped = (pix > fs);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> src/xal_sq_stage.sv
`default_nettype none

module xal_sq_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire xal_pkg::xal_lane_type  in_data,
   output logic                        in_ready,
   output logic                        out_valid,
   output xal_pkg::xal_lane_type       out_data,
   input  wire logic                   out_ready
);
   import xal_pkg::*;

   logic         valid_ff;
   xal_lane_type data_ff;
   xal_lane_type data_in;
   xal_sq_type   sq;

   // Square the mantissa, shift the new bit into the fraction
   always_comb begin
      sq = sq_step(in_data.m);
      data_in = in_data;
      data_in.m = sq.m;
      data_in.frac = {in_data.frac[FRAC_BITS-2:0], sq.frac_bit};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> src/xal_fs_log.sv
`default_nettype none

module xal_fs_log (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [xal_pkg::PORT_W-1:0]     csr_wr_data,
   output logic [xal_pkg::PIXEL_BITS-1:0]      fs,
   output logic [xal_pkg::LOG_W-1:0]           lfs,
   output logic                                busy
);
   import xal_pkg::*;

   logic [PIXEL_BITS-1:0] fs_ff;
   logic [PIXEL_BITS-1:0] fs_in;
   logic                  busy_ff;
   logic [ITER_W-1:0]     cnt_ff;
   logic [M_W-1:0]        m_ff;
   logic [FRAC_BITS-1:0]  frac_ff;
   logic [K_W-1:0]        k_ff;
   xal_norm_type          norm;
   xal_sq_type            sq;

   // Start value: the written register, or the reset value
   always_comb begin
      fs_in = fix_pix(reset ? FS_RESET : csr_wr_data);
      norm = normalize(fs_in);
      sq = sq_step(m_ff);
   end

   // Control: one fraction bit per cycle while busy
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == ITER_W'(FRAC_BITS - 1)) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + ITER_W'(1);
      end
   end

   // Data path of the iteration
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         fs_ff <= fs_in;
         k_ff <= norm.k;
         m_ff <= norm.m;
         frac_ff <= '0;
      end else if (busy_ff) begin
         m_ff <= sq.m;
         frac_ff <= {frac_ff[FRAC_BITS-2:0], sq.frac_bit};
      end
   end

   assign fs   = fs_ff;
   assign lfs  = {k_ff, frac_ff};
   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> src/xal_scale.sv
`default_nettype none

module xal_scale (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire xal_pkg::xal_lane_type      in_data,
   input  wire logic [xal_pkg::LOG_W-1:0]  lfs,
   output logic                            in_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [xal_pkg::ATT_W-1:0]       rsp_attenuation,
   output logic                            rsp_clamped
);
   import xal_pkg::*;

   logic                v1_ff, v2_ff, v3_ff;
   logic                r1, r2, r3;
   logic [LOG_W-1:0]    d_ff;
   logic [LOG_W-1:0]    d_in;
   logic                c1_ff, c2_ff, c3_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [SUM_W-1:0]    sum;
   logic [ATT_W-1:0]    att_ff;
   logic [ATT_W-1:0]    att_in;

   // Stage readiness, back from the output
   assign r3 = !v3_ff || !rsp_stall;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   // Log difference, ln2 scaling, rounding
   always_comb begin
      d_in = lfs - {in_data.k, in_data.frac};
      prod_in = PROD_W'(d_ff) * PROD_W'(LN2_Q32);
      sum = SUM_W'(prod_ff) + ROUND_ADD;
      att_in = c2_ff ? '0 : sum[ATT_SHIFT+ATT_W-1:ATT_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         d_ff <= d_in;
         c1_ff <= in_data.clamped;
      end
      if (r2) begin
         prod_ff <= prod_in;
         c2_ff <= c1_ff;
      end
      if (r3) begin
         att_ff <= att_in;
         c3_ff <= c2_ff;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_attenuation = att_ff;
   assign rsp_clamped     = c3_ff;

endmodule

`default_nettype wire
